// ===== rtl/eia_pkg.sv =====
// ----------------------------------------------------------------------------
// Extended integer ALU package
// Operation and operand kind codes shared by the extended integer ALU.
// ----------------------------------------------------------------------------
package eia_pkg;

    // Default width of an operand value.
    localparam int DEF_VALUE_BITS = 32;

    // Operation codes.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    // Operand and result kinds.
    localparam logic [1:0] KIND_FIN = 2'd0;
    localparam logic [1:0] KIND_POS = 2'd1;
    localparam logic [1:0] KIND_NEG = 2'd2;

endpackage

// ===== rtl/extended_integer_alu_top.sv =====
// ----------------------------------------------------------------------------
// Extended integer ALU
// Add, subtract, multiply, truncating divide and compare on integers that
// may also be plus or minus infinity.
//
// While o_stall is low the input channel takes one word per cycle: an
// operation code and two operands, each a kind (finite, plus or minus
// infinity) and a signed value. The output channel returns one word per
// input word: the result kind and value, an undefined-operation flag, and
// the less-than and equality flags. Both channels use valid and stall; a
// word moves when valid is high and stall is low.
//
// The pipeline has one input register, one decode and multiply stage,
// VALUE_BITS restoring divider stages (one quotient bit each) and an output
// register. Throughput is one word per cycle while the receiver does not
// stall. When the receiver stalls while a result is waiting, the whole
// pipeline holds and o_stall is raised; nothing is lost or repeated. Reset
// clears all valid bits, emptying the pipeline.
// ----------------------------------------------------------------------------
module extended_integer_alu_top
    import eia_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_req_type,
    input  logic [1:0]            i_left_kind,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic [1:0]            i_right_kind,
    input  logic [VALUE_BITS-1:0] i_right_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [1:0]            o_result_kind,
    output logic [VALUE_BITS-1:0] o_result_value,
    output logic                  o_undefined_error,
    output logic                  o_left_less,
    output logic                  o_operands_equal
);

    localparam int W = VALUE_BITS;

    // Side information that travels with each word through the divider.
    typedef struct packed {
        logic [1:0]   kind;
        logic [W-1:0] val;
        logic         err;
        logic         less;
        logic         eq;
        logic         use_div;
        logic         qneg;
    } t_side;

    // The pipeline advances as a whole unless a waiting result is stalled.
    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // Input register.
    logic         r_a_vld;
    logic [2:0]   r_a_op;
    logic [1:0]   r_a_lk;
    logic [W-1:0] r_a_lv;
    logic [1:0]   r_a_rk;
    logic [W-1:0] r_a_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= i_valid;
        end
        if (adv) begin
            r_a_op <= i_req_type;
            r_a_lk <= i_left_kind;
            r_a_lv <= i_left_value;
            r_a_rk <= i_right_kind;
            r_a_rv <= i_right_value;
        end
    end

    // Decode, special cases, compare flags, add, subtract and multiply.
    logic         lpos, lneg, linf, rpos, rneg, rinf, lzero, rzero, lsn, rsn;
    logic [W-1:0] lmag, rmag;
    logic [W-1:0] prod;
    t_side        n_side0;

    always_comb begin
        lpos  = (r_a_lk == KIND_POS);
        lneg  = (r_a_lk == KIND_NEG);
        linf  = lpos || lneg;
        rpos  = (r_a_rk == KIND_POS);
        rneg  = (r_a_rk == KIND_NEG);
        rinf  = rpos || rneg;
        lzero = !linf && (r_a_lv == '0);
        rzero = !rinf && (r_a_rv == '0);
        lsn   = r_a_lv[W-1];
        rsn   = r_a_rv[W-1];
        lmag  = lsn ? (~r_a_lv + 1'b1) : r_a_lv;
        rmag  = rsn ? (~r_a_rv + 1'b1) : r_a_rv;
        // Only the low half of the product is kept, so it wraps.
        prod  = r_a_lv * r_a_rv;

        n_side0         = '0;
        n_side0.kind    = KIND_FIN;
        n_side0.qneg    = lsn ^ rsn;

        // Ordering flags, given for every operation.
        if ((lpos && rpos) || (lneg && rneg) || (!linf && !rinf && r_a_lv == r_a_rv)) begin
            n_side0.eq = 1'b1;
        end else if (lpos || rneg) begin
            n_side0.less = 1'b0;
        end else if (lneg || rpos) begin
            n_side0.less = 1'b1;
        end else begin
            n_side0.less = ($signed(r_a_lv) < $signed(r_a_rv));
        end

        unique case (r_a_op)
            OP_ADD: begin
                if ((lpos && rneg) || (lneg && rpos)) n_side0.err = 1'b1;
                else if (lpos || rpos) n_side0.kind = KIND_POS;
                else if (lneg || rneg) n_side0.kind = KIND_NEG;
                else n_side0.val = r_a_lv + r_a_rv;
            end
            OP_SUB: begin
                if ((lpos && rpos) || (lneg && rneg)) n_side0.err = 1'b1;
                else if (lpos || rneg) n_side0.kind = KIND_POS;
                else if (lneg || rpos) n_side0.kind = KIND_NEG;
                else n_side0.val = r_a_lv - r_a_rv;
            end
            OP_MUL: begin
                if ((lzero && rinf) || (rzero && linf)) n_side0.err = 1'b1;
                else if (linf || rinf) begin
                    n_side0.kind = ((linf ? lneg : lsn) != (rinf ? rneg : rsn))
                                   ? KIND_NEG : KIND_POS;
                end else n_side0.val = prod;
            end
            OP_DIV: begin
                if ((linf && rinf) || rzero) n_side0.err = 1'b1;
                else if (linf) n_side0.kind = (lneg != rsn) ? KIND_NEG : KIND_POS;
                else if (!rinf) n_side0.use_div = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Divider stages: index 0 is loaded from decode, index k has k quotient bits.
    logic         r_dv_vld  [0:W];
    t_side        r_dv_side [0:W];
    logic [W-1:0] r_dv_rem  [0:W];
    logic [W-1:0] r_dv_q    [0:W];
    logic [W-1:0] r_dv_d    [0:W];
    logic [W-1:0] n_rem     [1:W];
    logic [W-1:0] n_q       [1:W];
    logic [W:0]   sh        [1:W];
    logic [W:0]   diff      [1:W];

    // One restoring step per stage.
    always_comb begin
        for (int k = 1; k <= W; k++) begin
            sh[k]   = {r_dv_rem[k-1], r_dv_q[k-1][W-1]};
            diff[k] = sh[k] - {1'b0, r_dv_d[k-1]};
            if (!diff[k][W]) begin
                n_rem[k] = diff[k][W-1:0];
            end else begin
                n_rem[k] = sh[k][W-1:0];
            end
            n_q[k] = {r_dv_q[k-1][W-2:0], !diff[k][W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= W; k++) r_dv_vld[k] <= 1'b0;
        end else if (adv) begin
            r_dv_vld[0] <= r_a_vld;
            for (int k = 1; k <= W; k++) r_dv_vld[k] <= r_dv_vld[k-1];
        end
        if (adv) begin
            r_dv_side[0] <= n_side0;
            r_dv_rem[0]  <= '0;
            r_dv_q[0]    <= lmag;
            r_dv_d[0]    <= rmag;
            for (int k = 1; k <= W; k++) begin
                r_dv_side[k] <= r_dv_side[k-1];
                r_dv_rem[k]  <= n_rem[k];
                r_dv_q[k]    <= n_q[k];
                r_dv_d[k]    <= r_dv_d[k-1];
            end
        end
    end

    // Output register with the quotient sign applied.
    t_side        fin;
    logic [W-1:0] quo;
    logic         r_out_vld;
    t_side        r_out;

    always_comb begin
        fin = r_dv_side[W];
        quo = fin.qneg ? (~r_dv_q[W] + 1'b1) : r_dv_q[W];
        if (fin.use_div) fin.val = quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_dv_vld[W];
        end
        if (adv) begin
            r_out <= fin;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_result_kind     = r_out.kind;
    assign o_result_value    = r_out.val;
    assign o_undefined_error = r_out.err;
    assign o_left_less       = r_out.less;
    assign o_operands_equal  = r_out.eq;

endmodule
